[sv/dbl_pkg.sv]
// ----------------------------------------------------------------------------
// dbl_pkg: shared types and constants of the bounded deque
// Command codes, status codes and the command word that drives the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package dbl_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ActionW = 3;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_APPEND_BACK  = 3'd0,
    ACT_LIST_FWD     = 3'd1,
    ACT_LIST_BWD     = 3'd2,
    ACT_REMOVE_FRONT = 3'd3,
    ACT_REMOVE_BACK  = 3'd4,
    ACT_INSERT_FRONT = 3'd5
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  // Operation applied by every cell of the row in the same cycle.
  typedef enum logic [2:0] {
    OP_HOLD,       // keep contents
    OP_APPEND,     // the cell at the fill level takes the new value
    OP_PUSH_FRONT, // shift toward the back, cell 0 takes the new value
    OP_POP_FRONT,  // shift toward the front
    OP_ROT_FWD,    // rotate occupied cells toward the front
    OP_ROT_BWD     // rotate occupied cells toward the back
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic signed [DataW-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

[sv/dbl_in_if.sv]
// ----------------------------------------------------------------------------
// dbl_in_if: command channel of the bounded deque
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

[sv/dbl_out_if.sv]
// ----------------------------------------------------------------------------
// dbl_out_if: result channel of the bounded deque
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output element, output status, output last, input ready);
  modport sink   (input valid, input element, input status, input last, output ready);
endinterface

`default_nettype wire

[sv/dbl_cell.sv]
// ----------------------------------------------------------------------------
// dbl_cell: one storage position of the deque row
// Holds the element at a fixed distance from the front and takes a new value
// from the command, its neighbors or the row ends as the command selects.
// ----------------------------------------------------------------------------
`default_nettype none

module dbl_cell #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned INDEX = 0,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire                              clk_i,
  input  wire dbl_pkg::cell_cmd_t          cmd_i,
  input  wire [CntW-1:0]                   count_i,
  input  wire signed [dbl_pkg::DataW-1:0]  prev_i,
  input  wire signed [dbl_pkg::DataW-1:0]  next_i,
  input  wire signed [dbl_pkg::DataW-1:0]  head_i,
  input  wire signed [dbl_pkg::DataW-1:0]  tail_i,
  output logic signed [dbl_pkg::DataW-1:0] value_o
);

  logic                            at_fill;
  logic                            is_last;
  logic                            we;
  logic signed [dbl_pkg::DataW-1:0] value_d;
  logic signed [dbl_pkg::DataW-1:0] value_q;

  assign at_fill = (count_i == CntW'(INDEX));
  assign is_last = (count_i == CntW'(INDEX + 1));

  always_comb begin
    we      = 1'b1;
    value_d = value_q;
    case (cmd_i.op)
      dbl_pkg::OP_APPEND: begin
        we      = at_fill;
        value_d = cmd_i.value;
      end
      dbl_pkg::OP_PUSH_FRONT: value_d = (INDEX == 0) ? cmd_i.value : prev_i;
      dbl_pkg::OP_POP_FRONT:  value_d = next_i;
      dbl_pkg::OP_ROT_FWD:    value_d = is_last ? head_i : next_i;
      dbl_pkg::OP_ROT_BWD:    value_d = (INDEX == 0) ? tail_i : prev_i;
      default:                we      = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

[sv/bounded_deque_with_listing.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_listing: bounded double-ended queue with listings
// Append, insert, list and remove commands are accepted while the sequencer
// is idle and the output register is free; each result word is registered.
// Append and insert sustain one command per cycle when the sink is ready.
// A listing gives one word per element (a single empty-status word if empty);
// a removal answers with the listing of what it leaves.
// Reset empties the queue and clears the sequencer; cell contents stay stale.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_listing #(
  parameter int unsigned DEPTH = 32
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  dbl_in_if.sink  in_i,
  dbl_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  // The sequencer is either taking commands or walking a listing.
  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  state_e                           state_q, state_d;
  logic                             dir_bwd_q, dir_bwd_d;
  logic [IdxW-1:0]                  idx_q, idx_d;
  logic [CntW-1:0]                  count_q, count_d;
  logic                             out_valid_q, out_valid_d;
  logic signed [dbl_pkg::DataW-1:0] out_elem_q, out_elem_d;
  dbl_pkg::status_e                 out_status_q, out_status_d;
  logic                             out_last_q, out_last_d;

  dbl_pkg::cell_cmd_t               cmd;
  logic signed [dbl_pkg::DataW-1:0] cell_val [DEPTH];
  logic signed [dbl_pkg::DataW-1:0] head_val;
  logic signed [dbl_pkg::DataW-1:0] tail_val;

  logic out_free;
  logic accept;
  logic full;
  logic empty;
  logic list_last;

  // The output register is free when empty or when its word leaves now.
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept     = in_i.valid && in_i.ready;

  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign list_last = (CntW'(idx_q) == count_q - CntW'(1));

  // The front element always sits in cell 0; the back element is picked out
  // by the fill level, which is one read port over the row.
  assign head_val = cell_val[0];
  always_comb begin
    tail_val = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (count_q == CntW'(k + 1)) begin
        tail_val = cell_val[k];
      end
    end
  end

  // Command decode and listing walk. A listing rotates the occupied cells by
  // one position per word, so after N words the row is back where it began.
  always_comb begin
    state_d      = state_q;
    dir_bwd_d    = dir_bwd_q;
    idx_d        = idx_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_elem_d   = out_elem_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    cmd.op       = dbl_pkg::OP_HOLD;
    cmd.value    = in_i.value;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (dbl_pkg::action_e'(in_i.action))
            dbl_pkg::ACT_APPEND_BACK, dbl_pkg::ACT_INSERT_FRONT: begin
              out_valid_d = 1'b1;
              out_elem_d  = '0;
              out_last_d  = 1'b1;
              if (full) begin
                out_status_d = dbl_pkg::ST_FULL;
              end else begin
                out_status_d = dbl_pkg::ST_OK;
                count_d      = count_q + CntW'(1);
                cmd.op       = (in_i.action == dbl_pkg::ACT_APPEND_BACK) ?
                               dbl_pkg::OP_APPEND : dbl_pkg::OP_PUSH_FRONT;
              end
            end
            dbl_pkg::ACT_LIST_FWD, dbl_pkg::ACT_LIST_BWD: begin
              state_d   = S_LIST;
              dir_bwd_d = (in_i.action == dbl_pkg::ACT_LIST_BWD);
              idx_d     = '0;
            end
            dbl_pkg::ACT_REMOVE_FRONT, dbl_pkg::ACT_REMOVE_BACK: begin
              if (empty) begin
                out_valid_d  = 1'b1;
                out_elem_d   = '0;
                out_status_d = dbl_pkg::ST_NONE;
                out_last_d   = 1'b1;
              end else begin
                // Dropping the back only lowers the fill level.
                count_d   = count_q - CntW'(1);
                state_d   = S_LIST;
                dir_bwd_d = 1'b0;
                idx_d     = '0;
                if (in_i.action == dbl_pkg::ACT_REMOVE_FRONT) begin
                  cmd.op = dbl_pkg::OP_POP_FRONT;
                end
              end
            end
            default: begin
              // Unused command codes are consumed without effect.
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (empty) begin
            out_elem_d   = '0;
            out_status_d = dbl_pkg::ST_EMPTY;
            out_last_d   = 1'b1;
            state_d      = S_IDLE;
          end else begin
            out_elem_d   = dir_bwd_q ? tail_val : head_val;
            out_status_d = dbl_pkg::ST_OK;
            out_last_d   = list_last;
            cmd.op       = dir_bwd_q ? dbl_pkg::OP_ROT_BWD : dbl_pkg::OP_ROT_FWD;
            if (list_last) begin
              state_d = S_IDLE;
              idx_d   = '0;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dir_bwd_q    <= 1'b0;
      idx_q        <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_elem_q   <= '0;
      out_status_q <= dbl_pkg::ST_OK;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      dir_bwd_q    <= dir_bwd_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      out_elem_q   <= out_elem_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  // Row of storage cells; cell k holds the element k places from the front.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [dbl_pkg::DataW-1:0] prev_val;
    logic signed [dbl_pkg::DataW-1:0] next_val;

    if (g == 0) begin : g_first
      assign prev_val = tail_val;
    end else begin : g_mid_prev
      assign prev_val = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_final
      assign next_val = head_val;
    end else begin : g_mid_next
      assign next_val = cell_val[g+1];
    end

    dbl_cell #(
      .DEPTH (DEPTH),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count_q),
      .prev_i  (prev_val),
      .next_i  (next_val),
      .head_i  (head_val),
      .tail_i  (tail_val),
      .value_o (cell_val[g])
    );
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.element = out_elem_q;
  assign out_o.status  = out_status_q;
  assign out_o.last    = out_last_q;

endmodule

`default_nettype wire

[sim/bounded_deque_with_listing_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_deque_with_listing_tb: self-checking bench for the bounded deque
// Drives command words over the input channel under several idling mixes.
// A queue-based copy of the deque predicts every result word. A checker
// compares each accepted result word field by field with the oldest
// prediction. A watchdog ends the run if the channels fall silent.
// ----------------------------------------------------------------------------

module bounded_deque_with_listing_tb;

  localparam int unsigned DEPTH = 32;

  // A stall of this many cycles with no word moving on either channel is
  // far beyond anything a correct block shows under the idling used here.
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  // Command codes the block must ignore without a result.
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef enum {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic signed [31:0] element;
    dbl_pkg::status_e   status;
    logic               last;
  } deque_result_t;

  logic clk_i;
  logic rst_ni;

  dbl_in_if  cmd_if ();
  dbl_out_if res_if ();

  bounded_deque_with_listing #(
    .DEPTH (DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // Contents of the deque as the bench believes them to be, front first.
  logic signed [31:0] deque_model[$];
  // Result words predicted but not yet seen on the output channel.
  deque_result_t pending_results[$];

  // Chance in percent that the sender idles a cycle or the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  int unsigned error_count;
  int unsigned command_count;
  int unsigned result_count;
  int unsigned full_rejects;
  int unsigned empty_removes;
  int unsigned peak_fill;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void queue_result_word(input logic signed [31:0] elem,
                                            input dbl_pkg::status_e st, input logic fin);
    deque_result_t word;
    word.element = elem;
    word.status  = st;
    word.last    = fin;
    pending_results.push_back(word);
  endfunction

  // A listing walks the stored elements in the requested direction and marks
  // the final word; an empty deque answers with a single empty status word.
  function automatic void list_contents(input bit backward);
    int n;
    n = deque_model.size();
    if (n == 0) begin
      queue_result_word('0, dbl_pkg::ST_EMPTY, 1'b1);
    end else begin
      for (int k = 0; k < n; k++) begin
        queue_result_word(deque_model[backward ? n - 1 - k : k], dbl_pkg::ST_OK,
                          k == n - 1);
      end
    end
  endfunction

  // Updates the deque copy for one accepted command and predicts its words.
  function automatic void apply_command(input logic [2:0] act,
                                        input logic signed [31:0] val);
    command_count++;
    case (act)
      dbl_pkg::ACT_APPEND_BACK, dbl_pkg::ACT_INSERT_FRONT: begin
        if (deque_model.size() >= DEPTH) begin
          full_rejects++;
          queue_result_word('0, dbl_pkg::ST_FULL, 1'b1);
        end else begin
          if (act == dbl_pkg::ACT_APPEND_BACK) deque_model.push_back(val);
          else deque_model.push_front(val);
          queue_result_word('0, dbl_pkg::ST_OK, 1'b1);
        end
      end
      dbl_pkg::ACT_LIST_FWD: list_contents(1'b0);
      dbl_pkg::ACT_LIST_BWD: list_contents(1'b1);
      dbl_pkg::ACT_REMOVE_FRONT, dbl_pkg::ACT_REMOVE_BACK: begin
        if (deque_model.size() == 0) begin
          empty_removes++;
          queue_result_word('0, dbl_pkg::ST_NONE, 1'b1);
        end else begin
          if (act == dbl_pkg::ACT_REMOVE_FRONT) void'(deque_model.pop_front());
          else void'(deque_model.pop_back());
          // Both removals list what is left from the front.
          list_contents(1'b0);
        end
      end
      default: ;  // unused codes change nothing and answer nothing
    endcase
    if (deque_model.size() > peak_fill) peak_fill = deque_model.size();
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Called at a rising edge. An idle gap, if any, drops valid first; with no
  // gap, valid simply stays high so that words follow back to back.
  task automatic send_word(input logic [2:0] act, input logic signed [31:0] val);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.action <= act;
    cmd_if.value  <= val;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    apply_command(act, val);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 67; stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 67; end
      default:   begin send_idle_pct = 10; stall_pct = 10; end
    endcase
  endtask

  // Mostly fully random values, with the corner values mixed in now and then.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Fill level the random traffic steers toward. Empty and beyond-full
  // targets make it hammer removals from empty and rejected pushes.
  function automatic int unsigned pick_target();
    case ($urandom_range(9))
      0, 1:    return 0;
      2, 3:    return DEPTH + 2;
      default: return $urandom_range(DEPTH, 1);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    deque_result_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      result_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        $error("unexpected result word: element %0d status %0d last %0d",
               res_if.element, res_if.status, res_if.last);
      end else begin
        want = pending_results.pop_front();
        if (res_if.element !== want.element) begin
          error_count++;
          $error("element: expected %0d, got %0d", want.element, res_if.element);
        end
        if (res_if.status !== want.status) begin
          error_count++;
          $error("status: expected %0d, got %0d", want.status, res_if.status);
        end
        if (res_if.last !== want.last) begin
          error_count++;
          $error("last: expected %0d, got %0d", want.last, res_if.last);
        end
      end
    end
  end

  // The watchdog counts cycles in which no word moves on either channel.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    wait (rst_ni === 1'b1);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
          (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty listings, removals from empty, unused codes, the only element
  // leaving from either end, corner values and both listing directions.
  task automatic test_directed_corners();
    set_idling(IDLE_NONE);
    send_word(dbl_pkg::ACT_LIST_FWD, '0);
    send_word(dbl_pkg::ACT_LIST_BWD, '1);
    send_word(dbl_pkg::ACT_REMOVE_FRONT, '0);
    send_word(dbl_pkg::ACT_REMOVE_BACK, '1);
    send_word(ACT_UNUSED_6, 32'sh5555_5555);
    send_word(ACT_UNUSED_7, 32'shaaaa_aaaa);
    send_word(dbl_pkg::ACT_APPEND_BACK, VAL_MAX);
    send_word(dbl_pkg::ACT_REMOVE_BACK, '0);      // only element leaves by the back
    send_word(dbl_pkg::ACT_INSERT_FRONT, VAL_MIN);
    send_word(dbl_pkg::ACT_REMOVE_FRONT, '0);     // only element leaves by the front
    send_word(dbl_pkg::ACT_APPEND_BACK, -32'sd1);
    send_word(dbl_pkg::ACT_INSERT_FRONT, '0);
    send_word(dbl_pkg::ACT_APPEND_BACK, 32'sh5555_5555);
    send_word(dbl_pkg::ACT_INSERT_FRONT, 32'shaaaa_aaaa);
    send_word(dbl_pkg::ACT_APPEND_BACK, VAL_MIN);
    send_word(dbl_pkg::ACT_INSERT_FRONT, VAL_MAX);
    send_word(dbl_pkg::ACT_LIST_FWD, '0);
    send_word(dbl_pkg::ACT_LIST_BWD, '0);
    send_word(ACT_UNUSED_7, '1);                  // ignored with data present
    send_word(dbl_pkg::ACT_REMOVE_FRONT, '0);
    send_word(dbl_pkg::ACT_REMOVE_BACK, '0);
    send_word(dbl_pkg::ACT_LIST_BWD, '0);
  endtask

  // Fills the deque to capacity from both ends, checks that both pushes are
  // turned away when full, lists the full deque both ways and drains it.
  task automatic test_fill_to_capacity();
    set_idling(IDLE_BOTH);
    while (deque_model.size() < DEPTH) begin
      if ($urandom_range(7) == 0) begin
        send_word($urandom_range(1) ? dbl_pkg::ACT_LIST_FWD : dbl_pkg::ACT_LIST_BWD,
                  pick_value());
      end else begin
        send_word($urandom_range(1) ? dbl_pkg::ACT_APPEND_BACK : dbl_pkg::ACT_INSERT_FRONT,
                  pick_value());
      end
    end
    send_word(dbl_pkg::ACT_APPEND_BACK, pick_value());
    send_word(dbl_pkg::ACT_INSERT_FRONT, pick_value());
    send_word(dbl_pkg::ACT_LIST_FWD, '0);
    send_word(dbl_pkg::ACT_LIST_BWD, '0);
    while (deque_model.size() > 0) begin
      send_word($urandom_range(1) ? dbl_pkg::ACT_REMOVE_FRONT : dbl_pkg::ACT_REMOVE_BACK,
                pick_value());
    end
    send_word(dbl_pkg::ACT_REMOVE_BACK, '0);
  endtask

  // Random traffic that wanders the fill level between empty and full, with
  // listings and ignored codes sprinkled in. Ignored words are not counted.
  task automatic test_random_traffic(input idle_mode_e mode, input int unsigned n_words);
    int unsigned sent;
    int unsigned target;
    int unsigned pick;
    set_idling(mode);
    sent   = 0;
    target = pick_target();
    while (sent < n_words) begin
      if ($urandom_range(15) == 0) target = pick_target();
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_word($urandom_range(1) ? ACT_UNUSED_7 : ACT_UNUSED_6, pick_value());
      end else begin
        if (pick < 16) begin
          send_word($urandom_range(1) ? dbl_pkg::ACT_LIST_BWD : dbl_pkg::ACT_LIST_FWD,
                    pick_value());
        end else if (deque_model.size() < target) begin
          send_word($urandom_range(1) ? dbl_pkg::ACT_INSERT_FRONT : dbl_pkg::ACT_APPEND_BACK,
                    pick_value());
        end else begin
          send_word($urandom_range(1) ? dbl_pkg::ACT_REMOVE_BACK : dbl_pkg::ACT_REMOVE_FRONT,
                    pick_value());
        end
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    error_count   = 0;
    command_count = 0;
    result_count  = 0;
    full_rejects  = 0;
    empty_removes = 0;
    peak_fill     = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_ni        = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.action = '0;
    cmd_if.value  = '0;
    res_if.ready  = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_fill_to_capacity();
    test_random_traffic(IDLE_NONE, 92);
    test_random_traffic(IDLE_SEND, 92);
    test_random_traffic(IDLE_RECV, 92);
    test_random_traffic(IDLE_BOTH, 92);

    // Drain: wait for every predicted word, then give a trailing result
    // time to show up, which the checker would flag as unexpected.
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("Ran %0d commands producing %0d result words under four idling mixes.",
             command_count, result_count);
    $display("Fill peaked at %0d of %0d; %0d pushes rejected as full, %0d removals from empty.",
             peak_fill, DEPTH, full_rejects, empty_removes);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
